// ----- rtl/first_fit_coalescing_allocator_unit_defines.svh -----
// Assertion macros shared by the allocator RTL
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define FFCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define FFCA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFCA_ASSERT(lbl, prop, msg)
`define FFCA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/ffca_pkg.sv -----
// Shared constants for the first-fit coalescing allocator
`timescale 1ns / 1ps
`default_nettype none
package ffca_pkg;
    localparam int OPCODE_W  = 1;
    localparam int REQ_W     = 32;
    localparam int SIZE_W    = 33;
    localparam int PAGES_W   = 21;
    localparam int STATUS_W  = 2;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NULL_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int PAGE_SHIFT   = 12;

    localparam logic [31:0] HEAP_START_RESET = 32'hFF00_0000;
endpackage
`default_nettype wire

// ----- rtl/ffca_cell.sv -----
// One cell of the segment chain: holds one (base, size) entry
`timescale 1ns / 1ps
`default_nettype none
module ffca_cell #(
    parameter int W = 96
) (
    input  wire logic         clk,
    input  wire logic         shift_en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);
    logic [W-1:0] entry_reg;

    // take the neighbor's entry on every pass cycle
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;
endmodule
`default_nettype wire

// ----- rtl/first_fit_coalescing_allocator_unit.sv -----
// Top level: first-fit free-list allocator with coalescing, built on a chain of cells
// Free segments sit in a chain of MAX_SEGMENTS cells in insertion order; every operation
// walks the chain in passes, each cell handing its entry to its neighbor and the head
// feeding a controller that writes the tail. Every item also has an accept step and a
// result step outside the passes. An allocate that fits makes one fit pass. A free makes
// one merge pass per merge plus a final merge pass and an insert pass; a null free makes
// none. An allocate that must grow the heap makes a fit pass, the merge and insert passes
// of a free, and a second fit pass; a full table cuts the remaining passes short. Merges
// are normally zero to two, more only when zero-length segments touch. One item is in work
// at a time; the result register lets the next item enter while the last result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_coalescing_allocator_unit_defines.svh"
module first_fit_coalescing_allocator_unit #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ffca_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [ffca_pkg::REQ_W-1:0]        request_size,
    input  wire logic [ADDR_BITS-1:0]              block_address,
    input  wire logic [ffca_pkg::SIZE_W-1:0]       freed_size,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [ADDR_BITS-1:0]              user_address,
    output logic      [ffca_pkg::SIZE_W-1:0]       block_size,
    output logic      [ADDR_BITS-1:0]              grow_base,
    output logic      [ffca_pkg::PAGES_W-1:0]      grow_pages,
    output logic      [ffca_pkg::STATUS_W-1:0]     status,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ADDR_BITS-1:0]              heap_start
);
    import ffca_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int EW    = 2 * ADDR_BITS;
    localparam int CW    = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIT    = 3'd1;
    localparam logic [2:0] ST_MERGE  = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [IDX_W-1:0]      t_reg, t_next;
    logic                  skip_reg, skip_next;
    logic                  found_reg, found_next;
    logic                  ins_reg, ins_next;
    logic [EW-1:0]         buf_reg, buf_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0]  f_base_reg, f_base_next;
    logic [ADDR_BITS-1:0]  f_size_reg, f_size_next;
    logic [CNT_W-1:0]      p_reg, p_next;
    logic [SIZE_W-1:0]     need_reg, need_next;
    logic [PAGES_W-1:0]    pages_reg, pages_next;
    logic                  alloc_reg, alloc_next;
    logic                  grown_reg, grown_next;
    logic [ADDR_BITS-1:0]  heap_top_reg, heap_top_next;
    logic [ADDR_BITS-1:0]  res_user_reg, res_user_next;
    logic [SIZE_W-1:0]     res_bsize_reg, res_bsize_next;
    logic [ADDR_BITS-1:0]  res_gbase_reg, res_gbase_next;
    logic [PAGES_W-1:0]    res_gpages_reg, res_gpages_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]  out_user_reg, out_user_next;
    logic [SIZE_W-1:0]     out_bsize_reg, out_bsize_next;
    logic [ADDR_BITS-1:0]  out_gbase_reg, out_gbase_next;
    logic [PAGES_W-1:0]    out_gpages_reg, out_gpages_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic [EW-1:0]         cell_q [MAX_SEGMENTS];
    logic [EW-1:0]         emit;
    logic                  shift_en;
    logic [EW-1:0]         head;
    logic [ADDR_BITS-1:0]  head_base, head_size, head_end, f_end;
    logic [CNT_W-1:0]      t_ext;
    logic                  live, fit_hit, fit_exact, m_hit1, m_hit2, pass_end, in_accept;
    logic [CW-1:0]         size_ext, need_ext;
    logic [ADDR_BITS-1:0]  need_a, bytes_a;
    logic [SIZE_W-1:0]     need_sum, need_calc, page_sum;

    // chain of cells, tail fed by the controller
    genvar gi;
    generate
        for (gi = 0; gi < MAX_SEGMENTS; gi++)
        begin : g_cell
            logic [EW-1:0] cell_d;
            if (gi == MAX_SEGMENTS - 1)
            begin : g_tail
                assign cell_d = emit;
            end
            else
            begin : g_body
                assign cell_d = cell_q[gi + 1];
            end
            ffca_cell #(.W(EW)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_d),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    // head view and per-cycle compares
    assign head      = skip_reg ? cell_q[1] : cell_q[0];
    assign head_base = head[EW-1:ADDR_BITS];
    assign head_size = head[ADDR_BITS-1:0];
    assign head_end  = head_base + head_size;
    assign f_end     = f_base_reg + f_size_reg;
    assign t_ext     = CNT_W'(t_reg);
    assign live      = (t_ext < cnt_reg) && !found_reg;
    assign size_ext  = CW'(head_size);
    assign need_ext  = CW'(need_reg);
    assign need_a    = ADDR_BITS'(need_reg);
    assign bytes_a   = ADDR_BITS'({pages_reg, {PAGE_SHIFT{1'b0}}});
    assign fit_hit   = live && (size_ext >= need_ext);
    assign fit_exact = fit_hit && (size_ext == need_ext);
    assign m_hit1    = live && (head_base == f_end);
    assign m_hit2    = live && !m_hit1 && (head_end == f_base_reg);
    assign pass_end  = (t_reg == IDX_W'(MAX_SEGMENTS - 1));
    assign shift_en  = (state_reg == ST_FIT) || (state_reg == ST_MERGE)
                       || (state_reg == ST_INSERT);

    // request rounding and page count
    assign need_sum  = SIZE_W'(request_size) + SIZE_W'(HEADER_BYTES + ALIGN_BYTES - 1);
    assign need_calc = need_sum & ~SIZE_W'(ALIGN_BYTES - 1);
    assign page_sum  = need_calc + SIZE_W'(PAGE_BYTES - 1);

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // controller
    always_comb
    begin
        state_next      = state_reg;
        t_next          = t_reg;
        skip_next       = skip_reg;
        found_next      = found_reg;
        ins_next        = ins_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        f_base_next     = f_base_reg;
        f_size_next     = f_size_reg;
        p_next          = p_reg;
        need_next       = need_reg;
        pages_next      = pages_reg;
        alloc_next      = alloc_reg;
        grown_next      = grown_reg;
        heap_top_next   = heap_top_reg;
        res_user_next   = res_user_reg;
        res_bsize_next  = res_bsize_reg;
        res_gbase_next  = res_gbase_reg;
        res_gpages_next = res_gpages_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_user_next   = out_user_reg;
        out_bsize_next  = out_bsize_reg;
        out_gbase_next  = out_gbase_reg;
        out_gpages_next = out_gpages_reg;
        out_status_next = out_status_reg;
        emit            = head;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    heap_top_next = heap_start;
                end
                if (in_accept)
                begin
                    res_user_next   = '0;
                    res_bsize_next  = '0;
                    res_gbase_next  = '0;
                    res_gpages_next = '0;
                    res_status_next = STATUS_DONE;
                    need_next       = need_calc;
                    pages_next      = page_sum[SIZE_W-1:PAGE_SHIFT];
                    alloc_next      = (opcode == OP_ALLOC);
                    grown_next      = 1'b0;
                    t_next          = '0;
                    skip_next       = 1'b0;
                    found_next      = 1'b0;
                    ins_next        = 1'b0;
                    if (opcode == OP_ALLOC)
                    begin
                        state_next = ST_FIT;
                    end
                    else if (block_address == '0)
                    begin
                        res_status_next = STATUS_NULL_FREE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        f_base_next = block_address - ADDR_BITS'(HEADER_BYTES);
                        f_size_next = ADDR_BITS'(freed_size);
                        p_next      = cnt_reg;
                        state_next  = ST_MERGE;
                    end
                end
            end

            ST_FIT:
            begin
                t_next = t_reg + IDX_W'(1);
                if (fit_hit)
                begin
                    found_next     = 1'b1;
                    res_user_next  = head_base + ADDR_BITS'(HEADER_BYTES);
                    res_bsize_next = need_reg;
                    if (size_ext > need_ext)
                    begin
                        emit = {head_base + need_a, head_size - need_a};
                    end
                    else
                    begin
                        // exact fit: entry leaves, the rest slides up one
                        emit      = cell_q[1];
                        skip_next = 1'b1;
                    end
                end
                if (pass_end)
                begin
                    t_next     = '0;
                    skip_next  = 1'b0;
                    found_next = 1'b0;
                    if (found_reg || fit_hit)
                    begin
                        cnt_next   = cnt_reg - CNT_W'(skip_reg || fit_exact);
                        state_next = ST_DONE;
                    end
                    else if (!grown_reg)
                    begin
                        // grow the heap: release the new pages first
                        f_base_next = heap_top_reg;
                        f_size_next = bytes_a;
                        p_next      = cnt_reg;
                        state_next  = ST_MERGE;
                    end
                    else
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_MERGE:
            begin
                t_next = t_reg + IDX_W'(1);
                if (m_hit1 || m_hit2)
                begin
                    found_next = 1'b1;
                    skip_next  = 1'b1;
                    emit       = cell_q[1];
                    if (m_hit1)
                    begin
                        // floating segment absorbs the one after it
                        f_size_next = f_size_reg + head_size;
                        if (t_ext < p_reg)
                        begin
                            p_next = p_reg - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // the one before absorbs the floating segment
                        f_base_next = head_base;
                        f_size_next = head_size + f_size_reg;
                        p_next      = t_ext;
                    end
                end
                if (pass_end)
                begin
                    t_next     = '0;
                    skip_next  = 1'b0;
                    found_next = 1'b0;
                    ins_next   = 1'b0;
                    if (found_reg || m_hit1 || m_hit2)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    else if (cnt_reg == CNT_W'(MAX_SEGMENTS))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end

            ST_INSERT:
            begin
                t_next = t_reg + IDX_W'(1);
                if (t_ext == p_reg)
                begin
                    emit     = {f_base_reg, f_size_reg};
                    ins_next = 1'b1;
                    buf_next = cell_q[0];
                end
                else if (ins_reg)
                begin
                    emit     = buf_reg;
                    buf_next = cell_q[0];
                end
                else
                begin
                    emit = cell_q[0];
                end
                if (pass_end)
                begin
                    t_next     = '0;
                    skip_next  = 1'b0;
                    found_next = 1'b0;
                    ins_next   = 1'b0;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    if (alloc_reg)
                    begin
                        res_gbase_next  = heap_top_reg;
                        res_gpages_next = pages_reg;
                        heap_top_next   = heap_top_reg + bytes_a;
                        grown_next      = 1'b1;
                        state_next      = ST_FIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_user_next   = res_user_reg;
                    out_bsize_next  = res_bsize_reg;
                    out_gbase_next  = res_gbase_reg;
                    out_gpages_next = res_gpages_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            t_reg         <= '0;
            skip_reg      <= 1'b0;
            found_reg     <= 1'b0;
            ins_reg       <= 1'b0;
            cnt_reg       <= '0;
            heap_top_reg  <= ADDR_BITS'(HEAP_START_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            skip_reg      <= skip_next;
            found_reg     <= found_next;
            ins_reg       <= ins_next;
            cnt_reg       <= cnt_next;
            heap_top_reg  <= heap_top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        buf_reg        <= buf_next;
        f_base_reg     <= f_base_next;
        f_size_reg     <= f_size_next;
        p_reg          <= p_next;
        need_reg       <= need_next;
        pages_reg      <= pages_next;
        alloc_reg      <= alloc_next;
        grown_reg      <= grown_next;
        res_user_reg   <= res_user_next;
        res_bsize_reg  <= res_bsize_next;
        res_gbase_reg  <= res_gbase_next;
        res_gpages_reg <= res_gpages_next;
        res_status_reg <= res_status_next;
        out_user_reg   <= out_user_next;
        out_bsize_reg  <= out_bsize_next;
        out_gbase_reg  <= out_gbase_next;
        out_gpages_reg <= out_gpages_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign user_address = out_user_reg;
    assign block_size   = out_bsize_reg;
    assign grow_base    = out_gbase_reg;
    assign grow_pages   = out_gpages_reg;
    assign status       = out_status_reg;

    // checks
    `FFCA_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_SEGMENTS), "segment count overflow")
    `FFCA_ASSERT(a_skip_in_pass, skip_reg |-> (state_reg == ST_FIT || state_reg == ST_MERGE), "skip outside pass")
    `FFCA_ASSERT(a_accept_busy, in_accept |=> (state_reg != ST_IDLE), "accepted item not in work")
    `FFCA_ASSERT(a_out_hold, $fell(out_valid_reg) |-> $past(!out_stall), "result lost before transfer")
endmodule
`default_nettype wire

// ----- sim/first_fit_coalescing_allocator_unit_checker.sv -----
// Checker for the allocator: predicts each result from accepted transfers and compares
`timescale 1ns / 1ps
`default_nettype none
module first_fit_coalescing_allocator_unit_checker #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [ffca_pkg::OPCODE_W-1:0]    opcode,
    input  wire logic [ffca_pkg::REQ_W-1:0]       request_size,
    input  wire logic [ADDR_BITS-1:0]             block_address,
    input  wire logic [ffca_pkg::SIZE_W-1:0]      freed_size,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [ADDR_BITS-1:0]             user_address,
    input  wire logic [ffca_pkg::SIZE_W-1:0]      block_size,
    input  wire logic [ADDR_BITS-1:0]             grow_base,
    input  wire logic [ffca_pkg::PAGES_W-1:0]     grow_pages,
    input  wire logic [ffca_pkg::STATUS_W-1:0]    status,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [ADDR_BITS-1:0]             heap_start,
    output int                                    fail_count,
    output int                                    awaited
);
    import ffca_pkg::*;

    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef struct packed {
        addr_t                user;
        logic [SIZE_W-1:0]    bsize;
        addr_t                gbase;
        logic [PAGES_W-1:0]   gpages;
        logic [STATUS_W-1:0]  st;
    } alloc_result_t;

    // Mirror of the free-segment table
    addr_t         seg_base [0:MAX_SEGMENTS];
    addr_t         seg_len  [0:MAX_SEGMENTS];
    int            seg_cnt;
    addr_t         heap_brk;
    alloc_result_t expected_q[$];

    function automatic void remove_seg(int k);
        if (k >= seg_cnt)
            return;
        for (int i = k; i + 1 < seg_cnt; i++)
        begin
            seg_base[i] = seg_base[i + 1];
            seg_len[i]  = seg_len[i + 1];
        end
        seg_cnt--;
    endfunction

    // Merge the segment at cur with touching neighbors until none remain
    function automatic void merge_from(int cur);
        bit    merged;
        addr_t lo;
        addr_t hi;
        do
        begin
            merged = 0;
            lo = seg_base[cur];
            hi = seg_base[cur] + seg_len[cur];
            for (int i = 0; i < seg_cnt; i++)
            begin
                if (i != cur)
                begin
                    if (seg_base[i] == hi)
                    begin
                        seg_len[cur] = seg_len[cur] + seg_len[i];
                        remove_seg(i);
                        if (i < cur)
                            cur--;
                        merged = 1;
                        break;
                    end
                    if (addr_t'(seg_base[i] + seg_len[i]) == lo)
                    begin
                        seg_len[i] = seg_len[i] + seg_len[cur];
                        remove_seg(cur);
                        if (cur < i)
                            i--;
                        cur = i;
                        merged = 1;
                        break;
                    end
                end
            end
        end
        while (merged);
    endfunction

    // Append a segment and merge it; returns 0 when the table overflowed
    function automatic bit insert_seg(addr_t base, addr_t len);
        if (seg_cnt > MAX_SEGMENTS)
            seg_cnt = MAX_SEGMENTS;
        seg_base[seg_cnt] = base;
        seg_len[seg_cnt]  = len;
        seg_cnt++;
        merge_from(seg_cnt - 1);
        if (seg_cnt > MAX_SEGMENTS)
        begin
            seg_cnt--;
            return 0;
        end
        return 1;
    endfunction

    function automatic int find_fit(addr_t need);
        for (int i = 0; i < seg_cnt; i++)
            if (seg_len[i] >= need)
                return i;
        return seg_cnt;
    endfunction

    function automatic alloc_result_t predict_alloc(
        logic [OPCODE_W-1:0] op, logic [REQ_W-1:0] req, addr_t addr, logic [SIZE_W-1:0] fsz);
        alloc_result_t r;
        logic [63:0]   need;
        logic [63:0]   pages;
        int            k;
        bit            ok;
        addr_t         base;
        r = '0;
        if (op == OP_ALLOC)
        begin
            need = (64'(req) + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
            k = find_fit(addr_t'(need));
            ok = 1;
            if (k == seg_cnt)
            begin
                pages = (need + PAGE_BYTES - 1) / PAGE_BYTES;
                if (!insert_seg(heap_brk, addr_t'(pages * PAGE_BYTES)))
                begin
                    ok = 0;
                    r.st = STATUS_FULL;
                end
                else
                begin
                    r.gbase  = heap_brk;
                    r.gpages = PAGES_W'(pages);
                    heap_brk = heap_brk + addr_t'(pages * PAGE_BYTES);
                    k = find_fit(addr_t'(need));
                    if (k == seg_cnt)
                    begin
                        ok = 0;
                        r.st = STATUS_FULL;
                    end
                end
            end
            if (ok)
            begin
                base = seg_base[k];
                if (seg_len[k] > need)
                begin
                    seg_base[k] = base + addr_t'(need);
                    seg_len[k]  = seg_len[k] - addr_t'(need);
                end
                else
                    remove_seg(k);
                r.user  = base + addr_t'(HEADER_BYTES);
                r.bsize = SIZE_W'(need);
            end
        end
        else if (addr == 0)
            r.st = STATUS_NULL_FREE;
        else if (!insert_seg(addr - addr_t'(HEADER_BYTES), addr_t'(fsz)))
            r.st = STATUS_FULL;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
        fail_count++;
    endtask

    // Output side first, then a register write, then new input
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            seg_cnt    = 0;
            heap_brk   = addr_t'(HEAP_START_RESET);
            fail_count = 0;
            awaited    = 0;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result transfer", 64'(status), 64'(0));
                else
                begin
                    want = expected_q.pop_front();
                    if (user_address !== want.user)
                        report_mismatch("user_address", 64'(user_address), 64'(want.user));
                    if (block_size !== want.bsize)
                        report_mismatch("block_size", 64'(block_size), 64'(want.bsize));
                    if (grow_base !== want.gbase)
                        report_mismatch("grow_base", 64'(grow_base), 64'(want.gbase));
                    if (grow_pages !== want.gpages)
                        report_mismatch("grow_pages", 64'(grow_pages), 64'(want.gpages));
                    if (status !== want.st)
                        report_mismatch("status", 64'(status), 64'(want.st));
                end
            end
            if (cfg_valid && cfg_ready)
                heap_brk = heap_start;
            if (in_valid && !in_stall)
                expected_q.push_back(predict_alloc(opcode, request_size, block_address,
                                                   freed_size));
            awaited = expected_q.size();
        end
    end
endmodule
`default_nettype wire

// ----- sim/first_fit_coalescing_allocator_unit_tb.sv -----
// Testbench top: drives allocate/free traffic and heap moves, then gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module first_fit_coalescing_allocator_unit_tb;
    import ffca_pkg::*;

    localparam int  ADDR_BITS   = 48;
    localparam int  CYCLE_LIMIT = 6000000;
    localparam int  RAND_ITEMS  = 115;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef struct packed {
        addr_t             addr;
        logic [SIZE_W-1:0] len;
    } live_block_t;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 in_valid = 0;
    logic                 in_stall;
    logic [OPCODE_W-1:0]  opcode = OP_ALLOC;
    logic [REQ_W-1:0]     request_size = '0;
    addr_t                block_address = '0;
    logic [SIZE_W-1:0]    freed_size = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    addr_t                user_address;
    logic [SIZE_W-1:0]    block_size;
    addr_t                grow_base;
    logic [PAGES_W-1:0]   grow_pages;
    logic [STATUS_W-1:0]  status;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    addr_t                heap_start = '0;
    int                   fail_count;
    int                   awaited;

    int                   send_idle;
    int                   recv_idle;
    int                   cycles;
    int                   sent;
    int                   grown;
    int                   full_seen;
    live_block_t          live_q[$];

    always #1 clk = ~clk;

    first_fit_coalescing_allocator_unit #(.MAX_SEGMENTS(64), .ADDR_BITS(ADDR_BITS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .request_size(request_size),
        .block_address(block_address), .freed_size(freed_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .user_address(user_address), .block_size(block_size),
        .grow_base(grow_base), .grow_pages(grow_pages), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .heap_start(heap_start)
    );

    first_fit_coalescing_allocator_unit_checker #(.MAX_SEGMENTS(64), .ADDR_BITS(ADDR_BITS))
        u_checker (.*);

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // Track live blocks so frees hit real allocations
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (out_valid && !out_stall)
        begin
            if (block_size != 0)
                live_q.push_back('{addr: user_address, len: block_size});
            if (grow_pages != 0)
                grown++;
            if (status == STATUS_FULL)
                full_seen++;
        end
    end

    task automatic push_item(logic [OPCODE_W-1:0] op, logic [REQ_W-1:0] req, addr_t addr,
                             logic [SIZE_W-1:0] fsz);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid      <= 1;
        opcode        <= op;
        request_size  <= req;
        block_address <= addr;
        freed_size    <= fsz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Wait until every result has been taken and recorded
    task automatic drain;
        @(negedge clk);
        in_valid <= 0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Move the heap growth point; block is idle here
    task automatic move_heap(addr_t v);
        drain();
        @(negedge clk);
        cfg_valid  <= 1;
        heap_start <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic free_live(int idx);
        live_block_t b;
        b = live_q[idx];
        live_q.delete(idx);
        push_item(OP_FREE, $urandom, b.addr, b.len);
    endtask

    // Carve many small blocks and free every other one to overflow the table
    task automatic fragment_heap(addr_t far_heap);
        int first;
        for (int i = 0; i < 140; i++)
            push_item(OP_ALLOC, 48, '0, '0);
        drain();
        first = (live_q.size() > 140) ? live_q.size() - 140 : 0;
        for (int i = 0; i < 70 && first + i < live_q.size(); i++)
            free_live(first + i);
        move_heap(far_heap);
        push_item(OP_ALLOC, 32'hFFFF_FFFF, '0, '0);
        drain();
    endtask

    task automatic random_traffic(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                push_item(OP_ALLOC, $urandom_range(2000), addr_t'({$urandom, $urandom}),
                          SIZE_W'({$urandom, $urandom}));
            else if (pick < 60)
                push_item(OP_ALLOC, $urandom, '0, '0);
            else if (pick < 90 && live_q.size() != 0)
                free_live($urandom_range(live_q.size() - 1));
            else if (pick < 93)
                push_item(OP_FREE, $urandom, '0, SIZE_W'({$urandom, $urandom}));
            else if (pick < 96)
                push_item(OP_FREE, '0, addr_t'({$urandom, $urandom}), '0);
            else
                push_item(OP_FREE, '0, addr_t'({$urandom, $urandom}),
                          SIZE_W'({$urandom, $urandom}));
        end
    endtask

    initial
    begin
        addr_t heaps [6];
        heaps = '{48'h0, 48'hFFFF_FFFF_F000,
                  addr_t'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000,
                  48'hFF00_0000, addr_t'({$urandom, $urandom}), 48'hFFFF_FFFF_FFFF};
        send_idle = 37;
        recv_idle = 47;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: size extremes, exact fits, null and zero-length frees
        push_item(OP_ALLOC, 0, '0, '0);
        push_item(OP_ALLOC, 48, '0, '0);
        push_item(OP_ALLOC, 4080, '0, '0);
        push_item(OP_ALLOC, 32'hFFFF_FFFF, '0, '0);
        push_item(OP_ALLOC, 1, '0, '0);
        push_item(OP_FREE, '0, '0, 33'h1_FFFF_FFFF);
        push_item(OP_FREE, '0, 48'h10, '0);
        push_item(OP_FREE, '0, 48'hFFFF_FFFF_FFFF, 33'h1_FFFF_FFFF);
        drain();
        while (live_q.size() != 0)
            free_live(0);
        push_item(OP_FREE, '0, 48'hFF00_0010, '0);
        push_item(OP_ALLOC, 47, '0, '0);
        push_item(OP_ALLOC, 49, '0, '0);
        drain();

        // Phases: receiver-heavy idling, then sender-heavy, then none
        for (int p = 0; p < 6; p++)
        begin
            send_idle = (p < 2) ? 37 : (p < 4) ? 47 : 0;
            recv_idle = (p < 2) ? 47 : (p < 4) ? 37 : 0;
            move_heap(heaps[p]);
            random_traffic(RAND_ITEMS);
            if (p % 2 == 1)
                fragment_heap(heaps[(p + 3) % 6] ^ 48'h8000_0000_0000);
        end

        drain();
        repeat (600) @(posedge clk);
        $display("covered %0d transfers over 6 heap settings", sent);
        $display("%0d grew the heap, %0d hit a full table", grown, full_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
